[sv/stc_pkg.sv]
// Package for the scope trigger capture block: widths, register indexes,
// configuration and pipeline structs. Used by every module of the block.
package stc_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int TDATA_W       = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int THR_W         = 12;
  localparam int HYST_W        = 11;
  localparam int GAIN_W        = 16;
  localparam int OFFS_W        = 13;
  localparam int DEC_W         = 16;
  localparam int CENT_W        = SAMPLE_BITS + 1;
  localparam int PROD_W        = CENT_W + GAIN_W;
  localparam int FRAC_BITS     = 8;
  localparam int QUO_W         = PROD_W - FRAC_BITS;
  localparam int SUM_W         = QUO_W + 2;
  localparam int LVL_W         = THR_W + 2;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 5;
  localparam int FRAME_LEN_DEF = 128;

  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(2000);
  localparam logic [HYST_W-1:0] HYST_RST = HYST_W'(150);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(256);
  localparam logic [OFFS_W-1:0] OFFS_RST = '0;
  localparam logic [DEC_W-1:0]  DEC_RST  = DEC_W'(1);

  typedef enum logic [2:0] {
    REG_THRESHOLD  = 3'd0,
    REG_HYSTERESIS = 3'd1,
    REG_GAIN_Q8    = 3'd2,
    REG_OFFSET     = 3'd3,
    REG_DECIMATION = 3'd4,
    REG_TRIG_EN    = 3'd5,
    REG_EDGE_RISE  = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]         threshold;
    logic [HYST_W-1:0]        hysteresis;
    logic signed [GAIN_W-1:0] gain_q8;
    logic signed [OFFS_W-1:0] offset;
    logic [DEC_W-1:0]         decimation;
    logic                     trigger_enable;
    logic                     edge_rising;
  } cfg_t;

  // Product stage contents handed from the front end to the trigger stage.
  typedef struct packed {
    logic                     valid;
    logic                     keep;
    logic signed [PROD_W-1:0] prod;
  } prod_stage_t;

endpackage

[sv/stc_regs.sv]
// Configuration register file of the scope trigger capture block.
// APB-style write/read port; depends on stc_pkg.
module stc_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [stc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [stc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output stc_pkg::cfg_t                     cfg
);

  stc_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = stc_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold      <= stc_pkg::THR_RST;
      cfg.hysteresis     <= stc_pkg::HYST_RST;
      cfg.gain_q8        <= stc_pkg::GAIN_RST;
      cfg.offset         <= stc_pkg::OFFS_RST;
      cfg.decimation     <= stc_pkg::DEC_RST;
      cfg.trigger_enable <= 1'b0;
      cfg.edge_rising    <= 1'b1;
    end else if (wr) begin
      case (idx)
        stc_pkg::REG_THRESHOLD:  cfg.threshold      <= pwdata[stc_pkg::THR_W-1:0];
        stc_pkg::REG_HYSTERESIS: cfg.hysteresis     <= pwdata[stc_pkg::HYST_W-1:0];
        stc_pkg::REG_GAIN_Q8:    cfg.gain_q8        <= pwdata[stc_pkg::GAIN_W-1:0];
        stc_pkg::REG_OFFSET:     cfg.offset         <= pwdata[stc_pkg::OFFS_W-1:0];
        stc_pkg::REG_DECIMATION: cfg.decimation     <= pwdata[stc_pkg::DEC_W-1:0];
        stc_pkg::REG_TRIG_EN:    cfg.trigger_enable <= pwdata[0];
        stc_pkg::REG_EDGE_RISE:  cfg.edge_rising    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      stc_pkg::REG_THRESHOLD:  prdata = stc_pkg::APB_DATA_W'(cfg.threshold);
      stc_pkg::REG_HYSTERESIS: prdata = stc_pkg::APB_DATA_W'(cfg.hysteresis);
      stc_pkg::REG_GAIN_Q8:    prdata = stc_pkg::APB_DATA_W'(cfg.gain_q8);
      stc_pkg::REG_OFFSET:     prdata = stc_pkg::APB_DATA_W'(cfg.offset);
      stc_pkg::REG_DECIMATION: prdata = stc_pkg::APB_DATA_W'(cfg.decimation);
      stc_pkg::REG_TRIG_EN:    prdata = stc_pkg::APB_DATA_W'(cfg.trigger_enable);
      stc_pkg::REG_EDGE_RISE:  prdata = stc_pkg::APB_DATA_W'(cfg.edge_rising);
      default:                 prdata = '0;
    endcase
  end

endmodule

[sv/stc_front.sv]
// Front end: input register with decimation phase, then the gain multiply
// into the product register. Depends on stc_pkg.
module stc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  stc_pkg::cfg_t                     cfg,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [stc_pkg::SAMPLE_BITS-1:0]   sample_in,
  output stc_pkg::prod_stage_t              pst,
  input  logic                              pst_ready
);

  logic                              av;
  logic                              a_keep;
  logic [stc_pkg::SAMPLE_BITS-1:0]   a_sample;
  logic [stc_pkg::DEC_W-1:0]         decim_phase;
  logic [stc_pkg::DEC_W-1:0]         decim_phase_next;
  logic [stc_pkg::DEC_W:0]           phase_inc;
  logic [stc_pkg::DEC_W-1:0]         period;
  logic                              a_go;
  logic                              s_go;
  logic signed [stc_pkg::CENT_W-1:0] centered;
  logic signed [stc_pkg::PROD_W-1:0] prod_next;

  assign a_go     = av && (!pst.valid || pst_ready);
  assign s_tready = !av || a_go;
  assign s_go     = s_tvalid && s_tready;

  // A decimation setting of zero behaves as one.
  assign period    = (cfg.decimation == '0) ? stc_pkg::DEC_W'(1) : cfg.decimation;
  assign phase_inc = {1'b0, decim_phase} + 1'b1;
  assign decim_phase_next = (phase_inc >= {1'b0, period}) ? '0 :
                            phase_inc[stc_pkg::DEC_W-1:0];

  assign centered  = $signed({1'b0, a_sample}) -
                     $signed({1'b0, cfg.threshold});
  assign prod_next = centered * cfg.gain_q8;

  always_ff @(posedge clk) begin
    if (rst) begin
      av          <= 1'b0;
      decim_phase <= '0;
    end else begin
      if (s_go) begin
        av          <= 1'b1;
        decim_phase <= decim_phase_next;
      end else if (a_go) begin
        av <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_go) begin
      a_sample <= sample_in;
      a_keep   <= (decim_phase == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pst.valid <= 1'b0;
    end else if (a_go) begin
      pst.valid <= 1'b1;
    end else if (pst_ready) begin
      pst.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      pst.keep <= a_keep;
      pst.prod <= prod_next;
    end
  end

endmodule

[sv/stc_trigger.sv]
// Trigger stage: finishes the scaling (divide by 256, offset, clip), runs the
// hysteresis trigger and frame counter, and holds the output register.
// Depends on stc_pkg.
module stc_trigger #(
  parameter int FRAME_LEN = stc_pkg::FRAME_LEN_DEF,
  parameter int CNT_W     = $clog2(FRAME_LEN)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  stc_pkg::cfg_t                     cfg,
  input  stc_pkg::prod_stage_t              pst,
  output logic                              pst_ready,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [stc_pkg::SAMPLE_BITS-1:0]   frame_sample,
  output logic                              frame_last
);

  logic                               armed;
  logic                               armed_next;
  logic                               capturing;
  logic                               capturing_next;
  logic [CNT_W-1:0]                   capture_count;
  logic [CNT_W-1:0]                   capture_count_next;
  logic                               emit;
  logic                               last;
  logic                               start;
  logic                               b_go;
  logic signed [stc_pkg::QUO_W-1:0]   quo;
  logic                               round_up;
  logic signed [stc_pkg::SUM_W-1:0]   sum;
  logic [stc_pkg::SAMPLE_BITS-1:0]    scaled;
  logic signed [stc_pkg::LVL_W-1:0]   lvl_lo;
  logic signed [stc_pkg::LVL_W-1:0]   lvl_hi;
  logic signed [stc_pkg::LVL_W-1:0]   s_lvl;

  assign pst_ready = !m_tvalid || m_tready;
  assign b_go      = pst.valid && pst_ready;

  // Arithmetic shift floors; a negative product with a nonzero fraction
  // gets one added back so the quotient truncates toward zero.
  assign quo      = pst.prod[stc_pkg::PROD_W-1:stc_pkg::FRAC_BITS];
  assign round_up = pst.prod[stc_pkg::PROD_W-1] && (pst.prod[stc_pkg::FRAC_BITS-1:0] != '0);
  assign sum      = stc_pkg::SUM_W'(quo)
                  + $signed({{(stc_pkg::SUM_W-1){1'b0}}, round_up})
                  + $signed({{(stc_pkg::SUM_W-stc_pkg::THR_W){1'b0}}, cfg.threshold})
                  + stc_pkg::SUM_W'(cfg.offset);

  always_comb begin
    if (sum < 0) begin
      scaled = '0;
    end else if (sum > stc_pkg::SUM_W'(stc_pkg::SAMPLE_MAX)) begin
      scaled = stc_pkg::SAMPLE_BITS'(stc_pkg::SAMPLE_MAX);
    end else begin
      scaled = sum[stc_pkg::SAMPLE_BITS-1:0];
    end
  end

  assign lvl_lo = $signed({2'b00, cfg.threshold}) - $signed({3'b000, cfg.hysteresis});
  assign lvl_hi = $signed({2'b00, cfg.threshold}) + $signed({3'b000, cfg.hysteresis});
  assign s_lvl  = $signed({{(stc_pkg::LVL_W-stc_pkg::SAMPLE_BITS){1'b0}}, scaled});

  assign last = (capture_count == CNT_W'(FRAME_LEN - 1));

  always_comb begin
    armed_next         = cfg.trigger_enable ? armed : 1'b0;
    capturing_next     = capturing;
    capture_count_next = capture_count;
    start              = 1'b0;
    emit               = 1'b0;
    if (pst.keep) begin
      if (!capturing) begin
        if (!cfg.trigger_enable) begin
          start = 1'b1;
        end else if (cfg.edge_rising) begin
          if (!armed_next && (s_lvl < lvl_lo)) armed_next = 1'b1;
          if (armed_next && (s_lvl > lvl_hi)) start = 1'b1;
        end else begin
          if (!armed_next && (s_lvl > lvl_hi)) armed_next = 1'b1;
          if (armed_next && (s_lvl < lvl_lo)) start = 1'b1;
        end
      end
      if (capturing || start) begin
        emit       = 1'b1;
        armed_next = 1'b0;
        // A new frame always begins at count zero.
        if (start || last) begin
          capture_count_next = start ? CNT_W'(1) : '0;
        end else begin
          capture_count_next = capture_count + 1'b1;
        end
        capturing_next = !(capturing ? last : (FRAME_LEN == 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed         <= 1'b0;
      capturing     <= 1'b0;
      capture_count <= '0;
      m_tvalid      <= 1'b0;
    end else if (b_go) begin
      armed         <= armed_next;
      capturing     <= capturing_next;
      capture_count <= capture_count_next;
      m_tvalid      <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && emit) begin
      frame_sample <= scaled;
      frame_last   <= capturing ? last : 1'b0;
    end
  end

endmodule

[sv/scope_trigger_capture.sv]
// Top level of the scope trigger capture block: register file, front end
// (decimation and gain multiply) and trigger stage. Depends on stc_pkg.
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid/s_tready    tdata: adc_sample
//  m_*       out        m_tvalid/m_tready    tdata: frame_sample, tlast: frame_last
//  APB       in         psel/penable/pready  seven configuration registers
//
// One sample is accepted per cycle while the output is not stalled; a sample that
// is emitted passes through the input register, the product register and the
// output register in turn before it is offered on the output.
// The gain multiply has its own pipeline stage so the trigger path starts at
// a register. Reset is synchronous and clears all control state.
// A stalled output backs the pipeline up stage by stage; the input keeps
// accepting until every register holds a sample.
module scope_trigger_capture #(
  parameter int FRAME_LEN = stc_pkg::FRAME_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [stc_pkg::TDATA_W-1:0]       s_tdata,   // [11:0] adc_sample
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [stc_pkg::TDATA_W-1:0]       m_tdata,   // [11:0] frame_sample
  output logic                              m_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [stc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [stc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int CNT_W = $clog2(FRAME_LEN);

  stc_pkg::cfg_t                    cfg;
  stc_pkg::prod_stage_t             pst;
  logic                             pst_ready;
  logic [stc_pkg::SAMPLE_BITS-1:0]  frame_sample;

  stc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .sample_in (s_tdata[stc_pkg::SAMPLE_BITS-1:0]),
    .pst       (pst),
    .pst_ready (pst_ready)
  );

  stc_trigger #(
    .FRAME_LEN (FRAME_LEN),
    .CNT_W     (CNT_W)
  ) u_trigger (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pst          (pst),
    .pst_ready    (pst_ready),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .frame_sample (frame_sample),
    .frame_last   (m_tlast)
  );

  assign m_tdata = stc_pkg::TDATA_W'(frame_sample);

endmodule
